// ----- hdl/slc_pkg.sv -----
// ----------------------------------------------------------------------------
// slc_pkg
// Types and constants shared by the sorted list blocks.
// ----------------------------------------------------------------------------
package slc_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ACTION_W   = 3;
    localparam int STATUS_W   = 2;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT     = 3'd0,
        ACT_REM_CUR    = 3'd1,
        ACT_REM_FRONT  = 3'd2,
        ACT_START      = 3'd3,
        ACT_END        = 3'd4,
        ACT_ADVANCE    = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_NOCUR = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the input item
        logic compare;   // register the insert position
        logic execute;   // update list and cursor
        logic respond;   // load the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // output register can take a new item
    } t_dp_status;

endpackage

// ----- hdl/slc_if.sv -----
// ----------------------------------------------------------------------------
// slc_cmd_if / slc_res_if
// Valid/ready channels for list commands and their results.
// ----------------------------------------------------------------------------
interface slc_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [slc_pkg::ACTION_W-1:0]  action;
    logic [31:0]                   value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface slc_res_if;
    logic                          valid;
    logic                          ready;
    logic [slc_pkg::STATUS_W-1:0]  status;
    logic [4:0]                    count;
    logic                          has_current;
    logic [3:0]                    current_position;
    logic [31:0]                   current_value;

    modport source (output valid, output status, output count, output has_current,
                    output current_position, output current_value, input ready);
    modport sink   (input valid, input status, input count, input has_current,
                    input current_position, input current_value, output ready);
endinterface

// ----- hdl/slc_ctrl.sv -----
// ----------------------------------------------------------------------------
// slc_ctrl
// Sequences one item through capture, compare, update and response.
// ----------------------------------------------------------------------------
module slc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  slc_pkg::t_dp_status  i_status,
    output slc_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_EXEC = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.compare = 1'b0;
        o_cmd.execute = 1'b0;
        o_cmd.respond = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = S_RESP;
            end
            S_RESP: begin
                // hold until the previous result has been taken
                if (i_status.out_free) begin
                    o_cmd.respond = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/slc_dp.sv -----
// ----------------------------------------------------------------------------
// slc_dp
// Register-cell sorted list, cursor and output register.
// ----------------------------------------------------------------------------
module slc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  slc_pkg::t_dp_cmd                    i_cmd,
    output slc_pkg::t_dp_status                 o_status,
    input  logic [slc_pkg::ACTION_W-1:0]        i_action,
    input  logic [31:0]                         i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [slc_pkg::STATUS_W-1:0]        o_res_status,
    output logic [4:0]                          o_count,
    output logic                                o_has_current,
    output logic [3:0]                          o_current_position,
    output logic [31:0]                         o_current_value
);

    localparam int DEPTH = slc_pkg::DEPTH;
    localparam int IDX_W = slc_pkg::IDX_W;
    localparam int CNT_W = slc_pkg::CNT_W;

    // captured item
    slc_pkg::t_action  r_action;
    slc_pkg::t_value   r_value;
    slc_pkg::t_idx     r_ins_pos;

    // list state
    slc_pkg::t_value   r_entries [DEPTH];
    slc_pkg::t_value   n_entries [DEPTH];
    slc_pkg::t_cnt     r_count;
    slc_pkg::t_cnt     n_count;
    slc_pkg::t_idx     r_cursor;
    slc_pkg::t_idx     n_cursor;
    logic              r_cur_valid;
    logic              n_cur_valid;
    slc_pkg::t_status  r_status;
    slc_pkg::t_status  n_status;

    // output register
    logic                         r_out_valid;
    slc_pkg::t_status             r_out_status;
    slc_pkg::t_cnt                r_out_count;
    logic                         r_out_has;
    slc_pkg::t_idx                r_out_pos;
    slc_pkg::t_value              r_out_value;

    logic [DEPTH-1:0]  w_le;
    logic              w_has;
    logic              w_full;
    logic              w_empty;
    slc_pkg::t_idx     w_rm_pos;

    // entries at or below the new value, among the stored ones
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_le[i] = (CNT_W'(i) < r_count) && (r_entries[i] <= r_value);
        end
    end

    assign w_has    = r_cur_valid && ({1'b0, r_cursor} < r_count);
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_rm_pos = (r_action == slc_pkg::ACT_REM_FRONT) ? '0 : r_cursor;

    always_comb begin
        n_entries   = r_entries;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_cur_valid = r_cur_valid;
        n_status    = slc_pkg::ST_OK;
        case (r_action)
            slc_pkg::ACT_INSERT: begin
                if (w_full) begin
                    n_status = slc_pkg::ST_FULL;
                end else begin
                    // open a slot at the insert position
                    for (int i = 1; i < DEPTH; i++) begin
                        if (IDX_W'(i) > r_ins_pos) begin
                            n_entries[i] = r_entries[i-1];
                        end
                    end
                    n_entries[r_ins_pos] = r_value;
                    n_count     = r_count + 1'b1;
                    n_cursor    = r_ins_pos;
                    n_cur_valid = 1'b1;
                end
            end
            slc_pkg::ACT_REM_CUR: begin
                if (!w_has) begin
                    n_status = slc_pkg::ST_NOCUR;
                end else begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (IDX_W'(i) >= w_rm_pos) begin
                            n_entries[i] = r_entries[i+1];
                        end
                    end
                    n_count     = r_count - 1'b1;
                    n_cur_valid = ({1'b0, r_cursor} < (r_count - 1'b1));
                end
            end
            slc_pkg::ACT_REM_FRONT: begin
                if (w_empty) begin
                    n_status = slc_pkg::ST_EMPTY;
                end else begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (IDX_W'(i) >= w_rm_pos) begin
                            n_entries[i] = r_entries[i+1];
                        end
                    end
                    n_count     = r_count - 1'b1;
                    n_cursor    = '0;
                    n_cur_valid = (r_count != CNT_W'(1));
                end
            end
            slc_pkg::ACT_START: begin
                if (w_empty) begin
                    n_status = slc_pkg::ST_EMPTY;
                end else begin
                    n_cursor    = '0;
                    n_cur_valid = 1'b1;
                end
            end
            slc_pkg::ACT_END: begin
                if (w_empty) begin
                    n_status = slc_pkg::ST_EMPTY;
                end else begin
                    n_cursor    = IDX_W'(r_count - 1'b1);
                    n_cur_valid = 1'b1;
                end
            end
            slc_pkg::ACT_ADVANCE: begin
                if (!w_has) begin
                    n_status = slc_pkg::ST_NOCUR;
                end else if (({1'b0, r_cursor} + 1'b1) >= r_count) begin
                    n_cur_valid = 1'b0;
                end else begin
                    n_cursor = r_cursor + 1'b1;
                end
            end
            default: begin
                n_status = slc_pkg::ST_OK;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= slc_pkg::t_action'(i_action);
            r_value  <= slc_pkg::t_value'(i_value);
        end
        if (i_cmd.compare) begin
            r_ins_pos <= IDX_W'($countones(w_le));
        end
        if (i_cmd.execute) begin
            r_entries <= n_entries;
            r_status  <= n_status;
        end
        if (i_cmd.respond) begin
            r_out_status <= r_status;
            r_out_count  <= r_count;
            r_out_has    <= w_has;
            r_out_pos    <= w_has ? r_cursor : '0;
            r_out_value  <= w_has ? r_entries[r_cursor] : '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cursor    <= '0;
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.execute) begin
                r_count     <= n_count;
                r_cursor    <= n_cursor;
                r_cur_valid <= n_cur_valid;
            end
            if (i_cmd.respond) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_res_status       = r_out_status;
    assign o_count            = r_out_count;
    assign o_has_current      = r_out_has;
    assign o_current_position = r_out_pos;
    assign o_current_value    = r_out_value;

endmodule

// ----- hdl/sorted_list_with_cursor.sv -----
// ----------------------------------------------------------------------------
// sorted_list_with_cursor
// Each item is captured, its insert position registered, list and cursor
// updated, then its result loaded into the output register; the input takes
// no new item until then. A stalled result holds the next item in respond
// and keeps the input closed until the output register frees up.
// Reset: synchronous active-low; empties the list and clears the cursor.
// ----------------------------------------------------------------------------
module sorted_list_with_cursor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slc_cmd_if.sink     i_cmd,
    slc_res_if.source   o_res
);

    slc_pkg::t_dp_cmd     w_cmd;
    slc_pkg::t_dp_status  w_status;

    slc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    slc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_action           (i_cmd.action),
        .i_value            (i_cmd.value),
        .o_out_valid        (o_res.valid),
        .i_out_ready        (o_res.ready),
        .o_res_status       (o_res.status),
        .o_count            (o_res.count),
        .o_has_current      (o_res.has_current),
        .o_current_position (o_res.current_position),
        .o_current_value    (o_res.current_value)
    );

endmodule

// ----- bench/sorted_list_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_checker
// Watches the command and result channels of the sorted list, keeps its own
// copy of the list and cursor, and compares every result field by field.
// ----------------------------------------------------------------------------
module sorted_list_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    slc_cmd_if   i_cmd,
    slc_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results_checked,
    output int   o_status_seen [4]
);

    typedef struct packed {
        slc_pkg::t_status status;
        logic [4:0]       count;
        logic             has_cur;
        logic [3:0]       pos;
        logic [31:0]      value;
    } t_list_result;

    slc_pkg::t_value list_vals [slc_pkg::DEPTH];
    int              stored;
    int              cur_pos;
    bit              cur_on;
    t_list_result    expected_results [$];

    // Apply one command to the shadow list and return the result it implies.
    function automatic t_list_result apply_action(
        input logic [slc_pkg::ACTION_W-1:0] act,
        input logic [31:0]                  raw);
        t_list_result    r;
        slc_pkg::t_value val;
        int              slot;
        int              i;
        val      = slc_pkg::t_value'(raw);
        r.status = slc_pkg::ST_OK;
        case (act)
            slc_pkg::ACT_INSERT: begin
                if (stored >= slc_pkg::DEPTH) begin
                    r.status = slc_pkg::ST_FULL;
                end else begin
                    // land after any equal entries
                    slot = 0;
                    while (slot < stored && list_vals[slot] <= val) slot++;
                    for (i = stored; i > slot; i--) list_vals[i] = list_vals[i-1];
                    list_vals[slot] = val;
                    stored++;
                    cur_pos = slot;
                    cur_on  = 1'b1;
                end
            end
            slc_pkg::ACT_REM_CUR: begin
                if (!cur_on || cur_pos >= stored) begin
                    r.status = slc_pkg::ST_NOCUR;
                end else begin
                    for (i = cur_pos; i + 1 < stored; i++) list_vals[i] = list_vals[i+1];
                    stored--;
                    if (cur_pos >= stored) cur_on = 1'b0;
                end
            end
            slc_pkg::ACT_REM_FRONT: begin
                if (stored == 0) begin
                    r.status = slc_pkg::ST_EMPTY;
                end else begin
                    for (i = 0; i + 1 < stored; i++) list_vals[i] = list_vals[i+1];
                    stored--;
                    cur_pos = 0;
                    cur_on  = (stored != 0);
                end
            end
            slc_pkg::ACT_START: begin
                if (stored == 0) begin
                    r.status = slc_pkg::ST_EMPTY;
                end else begin
                    cur_pos = 0;
                    cur_on  = 1'b1;
                end
            end
            slc_pkg::ACT_END: begin
                if (stored == 0) begin
                    r.status = slc_pkg::ST_EMPTY;
                end else begin
                    cur_pos = stored - 1;
                    cur_on  = 1'b1;
                end
            end
            slc_pkg::ACT_ADVANCE: begin
                if (!cur_on || cur_pos >= stored) begin
                    r.status = slc_pkg::ST_NOCUR;
                end else if (cur_pos + 1 >= stored) begin
                    cur_on = 1'b0;
                end else begin
                    cur_pos++;
                end
            end
            default: ;  // unused codes leave everything as it is
        endcase
        r.count = 5'(stored);
        if (cur_on && cur_pos < stored) begin
            r.has_cur = 1'b1;
            r.pos     = 4'(cur_pos);
            r.value   = 32'(list_vals[cur_pos]);
        end else begin
            r.has_cur = 1'b0;
            r.pos     = '0;
            r.value   = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            o_fail_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_list_result got;
        t_list_result want;
        if (!i_rst_n) begin
            stored  = 0;
            cur_pos = 0;
            cur_on  = 1'b0;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.status  = slc_pkg::t_status'(i_res.status);
                got.count   = i_res.count;
                got.has_cur = i_res.has_current;
                got.pos     = i_res.current_position;
                got.value   = i_res.current_value;
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t ns: result with nothing expected, got status %0d count %0d",
                             $time, got.status, got.count);
                end else begin
                    want = expected_results.pop_front();
                    o_results_checked++;
                    o_status_seen[want.status]++;
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("count", 32'(want.count), 32'(got.count));
                    check_field("has_current", 32'(want.has_cur), 32'(got.has_cur));
                    check_field("current_position", 32'(want.pos), 32'(got.pos));
                    check_field("current_value", want.value, got.value);
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                expected_results.push_back(apply_action(i_cmd.action, i_cmd.value));
            o_pending <= expected_results.size();
        end
    end

endmodule

// ----- bench/sorted_list_with_cursor_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_with_cursor_tb
// Drives list commands through directed corner cases and random phases
// (filling, draining, cursor walks, mixed) with random idling on both channels.
// ----------------------------------------------------------------------------
module sorted_list_with_cursor_tb;

    localparam logic [slc_pkg::ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [slc_pkg::ACTION_W-1:0] ACT_SPARE_B = 3'd7;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int PHASE_ITEMS   = 60;
    localparam int RES_HOLD_LEN  = 64;
    localparam int IDLE_LIMIT    = 1000;
    localparam int DRAIN_CYCLES  = 8;

    typedef enum int {PH_FILL, PH_DRAIN, PH_WALK, PH_MIXED} t_phase;

    logic i_clk;
    logic i_rst_n;

    slc_cmd_if cmd_bus ();
    slc_res_if res_bus ();

    int fail_count;
    int pending;
    int results_checked;
    int status_seen [4];

    int     sent_by_action [8];
    int     counted;
    int     idle_cycles;
    int     hold_requests;
    int     holds_done;
    bit     quiet;
    t_phase phase;

    sorted_list_with_cursor uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    sorted_list_checker checker_inst (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd_bus),
        .i_res             (res_bus),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results_checked (results_checked),
        .o_status_seen     (status_seen)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one; none in quiet stretches.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return $urandom_range(0, 7);  // force duplicates
        if (r < 45) begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [slc_pkg::ACTION_W-1:0] pick_action(input t_phase ph);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return r[0] ? ACT_SPARE_A : ACT_SPARE_B;
        case (ph)
            PH_FILL: begin
                if (r < 78) return slc_pkg::ACT_INSERT;
                if (r < 86) return slc_pkg::ACT_ADVANCE;
                if (r < 93) return slc_pkg::ACT_REM_CUR;
                return slc_pkg::ACT_START;
            end
            PH_DRAIN: begin
                if (r < 40) return slc_pkg::ACT_REM_FRONT;
                if (r < 72) return slc_pkg::ACT_REM_CUR;
                if (r < 82) return slc_pkg::ACT_INSERT;
                if (r < 91) return slc_pkg::ACT_END;
                return slc_pkg::ACT_ADVANCE;
            end
            PH_WALK: begin
                if (r < 20) return slc_pkg::ACT_START;
                if (r < 32) return slc_pkg::ACT_END;
                if (r < 65) return slc_pkg::ACT_ADVANCE;
                if (r < 80) return slc_pkg::ACT_INSERT;
                if (r < 90) return slc_pkg::ACT_REM_CUR;
                return slc_pkg::ACT_REM_FRONT;
            end
            default: begin
                if (r < 35) return slc_pkg::ACT_INSERT;
                if (r < 50) return slc_pkg::ACT_REM_CUR;
                if (r < 62) return slc_pkg::ACT_REM_FRONT;
                if (r < 72) return slc_pkg::ACT_START;
                if (r < 82) return slc_pkg::ACT_END;
                return slc_pkg::ACT_ADVANCE;
            end
        endcase
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_cmd(input logic [slc_pkg::ACTION_W-1:0] act,
                            input logic [31:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_bus.valid  <= 1'b0;
            cmd_bus.action <= slc_pkg::ACTION_W'($urandom());
            cmd_bus.value  <= $urandom();
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid  <= 1'b1;
        cmd_bus.action <= act;
        cmd_bus.value  <= val;
        do @(posedge i_clk); while (!cmd_bus.ready);
        sent_by_action[act]++;
    endtask

    task automatic wait_all_results();
        cmd_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Result side: random ready, with one long hold-off on request.
    initial begin : result_sink
        int gap;
        res_bus.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_requests != holds_done) begin
                res_bus.ready <= 1'b0;
                repeat (RES_HOLD_LEN) @(posedge i_clk);
                holds_done++;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    res_bus.ready <= 1'b1;
                    @(posedge i_clk);
                end else begin
                    res_bus.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int n;
        int phase_no;
        logic [slc_pkg::ACTION_W-1:0] act;
        i_rst_n        <= 1'b0;
        cmd_bus.valid  <= 1'b0;
        cmd_bus.action <= slc_pkg::ACT_INSERT;
        cmd_bus.value  <= '0;
        quiet          = 1'b0;
        hold_requests  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: every guarded action must refuse
        send_cmd(slc_pkg::ACT_START, '0);
        send_cmd(slc_pkg::ACT_END, '0);
        send_cmd(slc_pkg::ACT_REM_FRONT, '0);
        send_cmd(slc_pkg::ACT_REM_CUR, '0);
        send_cmd(slc_pkg::ACT_ADVANCE, '0);
        send_cmd(ACT_SPARE_A, 32'hFFFF_FFFF);
        send_cmd(ACT_SPARE_B, 32'h1234_5678);
        // extremes and duplicates; equal values go behind existing ones
        send_cmd(slc_pkg::ACT_INSERT, 32'h8000_0000);
        send_cmd(slc_pkg::ACT_INSERT, 32'hFFFF_FFFF);
        send_cmd(slc_pkg::ACT_INSERT, 32'h0000_0000);
        send_cmd(slc_pkg::ACT_INSERT, 32'h8000_0000);
        send_cmd(slc_pkg::ACT_INSERT, 32'h0000_0000);
        // walk off the end, then act with no cursor
        send_cmd(slc_pkg::ACT_START, '0);
        send_cmd(slc_pkg::ACT_ADVANCE, '0);
        send_cmd(slc_pkg::ACT_END, '0);
        send_cmd(slc_pkg::ACT_ADVANCE, '0);
        send_cmd(slc_pkg::ACT_ADVANCE, '0);
        send_cmd(slc_pkg::ACT_REM_CUR, '0);
        // remove the last entry, then one in the middle, then the front
        send_cmd(slc_pkg::ACT_END, '0);
        send_cmd(slc_pkg::ACT_REM_CUR, '0);
        send_cmd(slc_pkg::ACT_START, '0);
        send_cmd(slc_pkg::ACT_ADVANCE, '0);
        send_cmd(slc_pkg::ACT_REM_CUR, '0);
        send_cmd(slc_pkg::ACT_REM_FRONT, '0);
        send_cmd(slc_pkg::ACT_REM_FRONT, '0);
        wait_all_results();

        counted  = 0;
        phase_no = 0;
        while (counted < RANDOM_ITEMS) begin
            phase = t_phase'((phase_no < 4) ? phase_no : $urandom_range(0, 3));
            quiet = ($urandom_range(0, 3) == 0);
            if (phase_no == 2) begin
                quiet = 1'b1;
                hold_requests <= hold_requests + 1;  // starve results, let input back up
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                act = pick_action(phase);
                send_cmd(act, pick_value());
                if (act <= slc_pkg::ACT_ADVANCE) counted++;
            end
            if (phase_no % 5 == 4) wait_all_results();
            phase_no++;
        end

        quiet = 1'b0;
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("commands: %0d insert, %0d remove current, %0d remove front, %0d start, %0d end,",
                 sent_by_action[slc_pkg::ACT_INSERT], sent_by_action[slc_pkg::ACT_REM_CUR],
                 sent_by_action[slc_pkg::ACT_REM_FRONT], sent_by_action[slc_pkg::ACT_START],
                 sent_by_action[slc_pkg::ACT_END]);
        $display("%0d advance, %0d unused codes; %0d results (%0d ok, %0d full, %0d empty, %0d no cursor)",
                 sent_by_action[slc_pkg::ACT_ADVANCE],
                 sent_by_action[ACT_SPARE_A] + sent_by_action[ACT_SPARE_B],
                 results_checked, status_seen[slc_pkg::ST_OK], status_seen[slc_pkg::ST_FULL],
                 status_seen[slc_pkg::ST_EMPTY], status_seen[slc_pkg::ST_NOCUR]);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
